>>> src/indexed_list_store_macros.svh
// Assertion macros shared by the indexed list store RTL.
// Included by the top level; depends on nothing else.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed list store: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed list store: next-cycle check failed");

`endif

>>> src/ils_pkg.sv
// Shared types and codes for the indexed list store.
// No dependencies; the other files that use it refer to it by scoped names.
package ils_pkg;

    localparam int ACTION_W = 4;
    localparam int IDX_IN_W = 5;
    localparam int VALUE_W  = 32;
    localparam int FOUND_W  = 4;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR     = 4'd0,
        ACT_INS_FIRST = 4'd1,
        ACT_INS_LAST  = 4'd2,
        ACT_INS_AT    = 4'd3,
        ACT_DEL_FIRST = 4'd4,
        ACT_DEL_LAST  = 4'd5,
        ACT_DEL_AT    = 4'd6,
        ACT_GET       = 4'd7,
        ACT_SET       = 4'd8,
        ACT_FIND      = 4'd9
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Memory work that the back end still has to do for an accepted item.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_DELETE,
        CMD_GET,
        CMD_SET,
        CMD_FIND
    } cmd_kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_READW,
        B_SHIFT,
        B_DRAIN,
        B_PUT,
        B_SCAN,
        B_DONE
    } back_state_t;

    typedef struct packed {
        cmd_kind_t         kind;
        status_t           status;
        logic [LEN_W-1:0]  length;
    } cmd_ctl_t;

endpackage

>>> src/ils_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on ils_pkg for field widths.
interface ils_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [ils_pkg::ACTION_W-1:0]         action;
    logic [ils_pkg::IDX_IN_W-1:0]         element_index;
    logic signed [ils_pkg::VALUE_W-1:0]   value_in;

    modport source (output valid, action, element_index, value_in, input ready);
    modport sink   (input valid, action, element_index, value_in, output ready);
endinterface

interface ils_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ils_pkg::VALUE_W-1:0]   value_out;
    logic [ils_pkg::FOUND_W-1:0]          found_index;
    logic [ils_pkg::LEN_W-1:0]            list_length;
    logic [ils_pkg::STATUS_W-1:0]         status;

    modport source (output valid, value_out, found_index, list_length, status, input ready);
    modport sink   (input valid, value_out, found_index, list_length, status, output ready);
endinterface

>>> src/ils_front.sv
// Front end: accepts request items, checks them against the running length
// and emits memory commands. Depends on ils_pkg and ils_if.
module ils_front #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ils_req_if.sink                     req,
    input  logic                        q_full,
    output logic                        q_push,
    output ils_pkg::cmd_ctl_t           cmd_ctl,
    output logic [$clog2(CAPACITY)-1:0]   cmd_pos,
    output logic [$clog2(CAPACITY+1)-1:0] cmd_cnt,
    output logic [DATA_WIDTH-1:0]       cmd_value
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ils_pkg::IDX_IN_W) ? CW : ils_pkg::IDX_IN_W;

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CMPW-1:0] idx_x;
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] cap_x;
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_after;
    logic [63:0]     value_ext;
    ils_pkg::action_t act;

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

    assign idx_x     = CMPW'(req.element_index);
    assign cnt_x     = CMPW'(count_reg);
    assign cap_x     = CMPW'(CAPACITY);
    assign act       = ils_pkg::action_t'(req.action);
    assign value_ext = 64'(req.value_in);

    always_comb
    begin
        cmd_ctl.kind   = ils_pkg::CMD_NONE;
        cmd_ctl.status = ils_pkg::ST_OK;
        pos_x          = '0;
        cnt_after      = cnt_x;
        unique case (act)
            ils_pkg::ACT_CLEAR:
            begin
                cnt_after = '0;
            end
            ils_pkg::ACT_INS_FIRST, ils_pkg::ACT_INS_LAST, ils_pkg::ACT_INS_AT:
            begin
                if (act == ils_pkg::ACT_INS_FIRST)
                begin
                    pos_x = '0;
                end
                else if (act == ils_pkg::ACT_INS_LAST)
                begin
                    pos_x = cnt_x;
                end
                else
                begin
                    pos_x = idx_x;
                end
                // The position check takes precedence over the full check.
                priority if (pos_x > cnt_x)
                begin
                    cmd_ctl.status = ils_pkg::ST_RANGE;
                end
                else if (cnt_x == cap_x)
                begin
                    cmd_ctl.status = ils_pkg::ST_FULL;
                end
                else
                begin
                    cmd_ctl.kind = ils_pkg::CMD_INSERT;
                    cnt_after    = cnt_x + CMPW'(1);
                end
            end
            ils_pkg::ACT_DEL_FIRST, ils_pkg::ACT_DEL_LAST, ils_pkg::ACT_DEL_AT:
            begin
                if (cnt_x == '0)
                begin
                    cmd_ctl.status = ils_pkg::ST_EMPTY;
                end
                else
                begin
                    if (act == ils_pkg::ACT_DEL_FIRST)
                    begin
                        pos_x = '0;
                    end
                    else if (act == ils_pkg::ACT_DEL_LAST)
                    begin
                        pos_x = cnt_x - CMPW'(1);
                    end
                    else
                    begin
                        pos_x = idx_x;
                    end
                    if (pos_x >= cnt_x)
                    begin
                        cmd_ctl.status = ils_pkg::ST_RANGE;
                    end
                    else
                    begin
                        cmd_ctl.kind = ils_pkg::CMD_DELETE;
                        cnt_after    = cnt_x - CMPW'(1);
                    end
                end
            end
            ils_pkg::ACT_GET, ils_pkg::ACT_SET:
            begin
                pos_x = idx_x;
                if (idx_x >= cnt_x)
                begin
                    cmd_ctl.status = ils_pkg::ST_RANGE;
                end
                else if (act == ils_pkg::ACT_GET)
                begin
                    cmd_ctl.kind = ils_pkg::CMD_GET;
                end
                else
                begin
                    cmd_ctl.kind = ils_pkg::CMD_SET;
                end
            end
            ils_pkg::ACT_FIND:
            begin
                if (cnt_x == '0)
                begin
                    cmd_ctl.status = ils_pkg::ST_NOTFOUND;
                end
                else
                begin
                    cmd_ctl.kind = ils_pkg::CMD_FIND;
                end
            end
            default:
            begin
                // Unused action codes leave the list alone and report ok.
                cnt_after = cnt_x;
            end
        endcase
        cmd_ctl.length = cnt_after[ils_pkg::LEN_W-1:0];
    end

    assign cmd_pos    = pos_x[IW-1:0];
    assign cmd_cnt    = count_reg;
    assign cmd_value  = value_ext[DATA_WIDTH-1:0];
    assign count_next = q_push ? cnt_after[CW-1:0] : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

>>> src/ils_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on nothing; the payload is a flat vector.
module ils_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         full,
    output logic         empty
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   fill_reg;
    logic [1:0]   fill_next;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> src/ils_back.sv
// Back end: element memory, the sequencer that shifts and scans it, and the
// response register. Depends on ils_pkg and ils_if.
module ils_back #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  ils_pkg::cmd_ctl_t             q_ctl,
    input  logic [$clog2(CAPACITY)-1:0]   q_pos,
    input  logic [$clog2(CAPACITY+1)-1:0] q_cnt,
    input  logic [DATA_WIDTH-1:0]         q_value,
    output logic                          q_pop,
    ils_rsp_if.source                     rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    ils_pkg::back_state_t state_reg, state_next;
    ils_pkg::cmd_kind_t   kind_reg, kind_next;
    ils_pkg::status_t     status_reg, status_next;
    logic [ils_pkg::LEN_W-1:0] len_reg, len_next;
    logic [IW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [DATA_WIDTH-1:0] vout_reg, vout_next;
    logic [IW-1:0]         found_reg, found_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic                  tag_vld_reg, tag_vld_next;
    logic [IW-1:0]         tag_addr_reg, tag_addr_next;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic                  ren;
    logic [IW-1:0]         raddr;
    logic                  wen;
    logic [IW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;

    logic                  out_vld_reg, out_vld_next;
    logic [ils_pkg::VALUE_W-1:0]  out_value_reg;
    logic [ils_pkg::FOUND_W-1:0]  out_found_reg;
    logic [ils_pkg::LEN_W-1:0]    out_len_reg;
    logic [ils_pkg::STATUS_W-1:0] out_status_reg;
    logic                  load_out;
    logic [63:0]           vout_wide;
    logic [15:0]           found_wide;

    assign vout_wide  = 64'(vout_reg);
    assign found_wide = 16'(found_reg);

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        status_next   = status_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        val_next      = val_reg;
        vout_next     = vout_reg;
        found_next    = found_reg;
        ptr_next      = ptr_reg;
        tag_vld_next  = 1'b0;
        tag_addr_next = tag_addr_reg;
        q_pop         = 1'b0;
        ren           = 1'b0;
        raddr         = ptr_reg[IW-1:0];
        wen           = 1'b0;
        waddr         = tag_addr_reg;
        wdata         = rdata_reg;
        load_out      = 1'b0;

        unique case (state_reg)
            ils_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    kind_next   = q_ctl.kind;
                    status_next = q_ctl.status;
                    len_next    = q_ctl.length;
                    pos_next    = q_pos;
                    cnt_next    = q_cnt;
                    val_next    = q_value;
                    vout_next   = '0;
                    found_next  = '0;
                    ptr_next    = '0;
                    unique case (q_ctl.kind)
                        ils_pkg::CMD_GET, ils_pkg::CMD_DELETE:
                        begin
                            state_next = ils_pkg::B_READ;
                        end
                        ils_pkg::CMD_SET:
                        begin
                            state_next = ils_pkg::B_PUT;
                        end
                        ils_pkg::CMD_INSERT:
                        begin
                            // Move the tail up one place, last element first.
                            if (CW'(q_pos) < q_cnt)
                            begin
                                ptr_next   = q_cnt - CW'(1);
                                state_next = ils_pkg::B_SHIFT;
                            end
                            else
                            begin
                                state_next = ils_pkg::B_PUT;
                            end
                        end
                        ils_pkg::CMD_FIND:
                        begin
                            state_next = ils_pkg::B_SCAN;
                        end
                        default:
                        begin
                            state_next = ils_pkg::B_DONE;
                        end
                    endcase
                end
            end
            ils_pkg::B_READ:
            begin
                ren        = 1'b1;
                raddr      = pos_reg;
                state_next = ils_pkg::B_READW;
            end
            ils_pkg::B_READW:
            begin
                vout_next = rdata_reg;
                // A delete closes the gap by moving the tail down one place.
                if ((kind_reg == ils_pkg::CMD_DELETE) && ((CW'(pos_reg) + CW'(1)) < cnt_reg))
                begin
                    ptr_next   = CW'(pos_reg) + CW'(1);
                    state_next = ils_pkg::B_SHIFT;
                end
                else
                begin
                    state_next = ils_pkg::B_DONE;
                end
            end
            ils_pkg::B_SHIFT:
            begin
                // Write back the element read last cycle while reading the next.
                wen          = tag_vld_reg;
                ren          = 1'b1;
                raddr        = ptr_reg[IW-1:0];
                tag_vld_next = 1'b1;
                if (kind_reg == ils_pkg::CMD_INSERT)
                begin
                    tag_addr_next = ptr_reg[IW-1:0] + IW'(1);
                    if (ptr_reg == CW'(pos_reg))
                    begin
                        state_next = ils_pkg::B_DRAIN;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - CW'(1);
                    end
                end
                else
                begin
                    tag_addr_next = ptr_reg[IW-1:0] - IW'(1);
                    if (ptr_reg == (cnt_reg - CW'(1)))
                    begin
                        state_next = ils_pkg::B_DRAIN;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + CW'(1);
                    end
                end
            end
            ils_pkg::B_DRAIN:
            begin
                wen = tag_vld_reg;
                if (kind_reg == ils_pkg::CMD_INSERT)
                begin
                    state_next = ils_pkg::B_PUT;
                end
                else
                begin
                    state_next = ils_pkg::B_DONE;
                end
            end
            ils_pkg::B_PUT:
            begin
                wen        = 1'b1;
                waddr      = pos_reg;
                wdata      = val_reg;
                state_next = ils_pkg::B_DONE;
            end
            ils_pkg::B_SCAN:
            begin
                // Reads stream one per cycle; each compare sees last cycle's read.
                if (tag_vld_reg && (rdata_reg == val_reg))
                begin
                    found_next = tag_addr_reg;
                    state_next = ils_pkg::B_DONE;
                end
                else if (ptr_reg < cnt_reg)
                begin
                    ren           = 1'b1;
                    raddr         = ptr_reg[IW-1:0];
                    tag_vld_next  = 1'b1;
                    tag_addr_next = ptr_reg[IW-1:0];
                    ptr_next      = ptr_reg + CW'(1);
                end
                else if (!tag_vld_reg)
                begin
                    status_next = ils_pkg::ST_NOTFOUND;
                    state_next  = ils_pkg::B_DONE;
                end
            end
            ils_pkg::B_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ils_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = ils_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        len_reg      <= len_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        val_reg      <= val_next;
        vout_reg     <= vout_next;
        found_reg    <= found_next;
        ptr_reg      <= ptr_next;
        tag_addr_reg <= tag_addr_next;
        if (load_out)
        begin
            out_value_reg  <= vout_wide[ils_pkg::VALUE_W-1:0];
            out_found_reg  <= found_wide[ils_pkg::FOUND_W-1:0];
            out_len_reg    <= len_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ils_pkg::B_IDLE;
            tag_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tag_vld_reg <= tag_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.value_out   = $signed(out_value_reg);
    assign rsp.found_index = out_found_reg;
    assign rsp.list_length = out_len_reg;
    assign rsp.status      = out_status_reg;

endmodule

>>> src/indexed_list_store.sv
// Top level of the indexed list store: front end, command queue, back end.
// Depends on ils_pkg, ils_if, ils_front, ils_queue, ils_back and the macros header.
//
//   Channel  Direction  Payload
//   req      in         action, element_index, value_in
//   rsp      out        value_out, found_index, list_length, status
//
// The front end takes one item per cycle while the two-entry queue has room;
// the back end then works each item against an element memory with one read
// port and one write port. Insert and delete walk each element they move, and
// find each element it searches; clear, failed requests and unused codes skip
// the element memory.
// Reset clears the length and the control state at once; there is no clearing
// pass, since an element position is only read after it has been written.
// A stalled response holds in its output register while up to three further
// items are accepted.
`include "indexed_list_store_macros.svh"

module indexed_list_store #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ils_req_if.sink   req,
    ils_rsp_if.source rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int QW = $bits(ils_pkg::cmd_ctl_t) + IW + CW + DATA_WIDTH;

    // Command handed from the front end to the back end.
    ils_pkg::cmd_ctl_t     f_ctl;
    logic [IW-1:0]         f_pos;
    logic [CW-1:0]         f_cnt;
    logic [DATA_WIDTH-1:0] f_value;

    ils_pkg::cmd_ctl_t     b_ctl;
    logic [IW-1:0]         b_pos;
    logic [CW-1:0]         b_cnt;
    logic [DATA_WIDTH-1:0] b_value;

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_out;

    // The front end keeps its own running length, so it can check items ahead
    // of the back end; the queue carries the length each command started from.
    ils_front #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .q_full    (q_full),
        .q_push    (q_push),
        .cmd_ctl   (f_ctl),
        .cmd_pos   (f_pos),
        .cmd_cnt   (f_cnt),
        .cmd_value (f_value)
    );

    assign q_in = {f_ctl, f_pos, f_cnt, f_value};

    ils_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {b_ctl, b_pos, b_cnt, b_value} = q_out;

    // The back end owns the element memory and the response register.
    ils_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_ctl   (b_ctl),
        .q_pos   (b_pos),
        .q_cnt   (b_cnt),
        .q_value (b_value),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

    // The back end only takes a command that the queue holds.
    `ILS_ASSERT_SAME(a_pop_not_empty, clk, rst_n, q_pop, !q_empty)
    // The front end never writes into a full queue.
    `ILS_ASSERT_SAME(a_push_not_full, clk, rst_n, q_push, !q_full)
    // A command pushed without a pop is waiting in the queue next cycle.
    `ILS_ASSERT_NEXT(a_push_lands, clk, rst_n, q_push && !q_pop, !q_empty)

endmodule
